FILE: hw/rtl/lppd_pkg.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer package
// Shared types, register map and status codes for the deframer.
// ----------------------------------------------------------------------------
package lppd_pkg;

   // Register map: index of each register, byte address is 4 * index
   localparam int unsigned CSR_ADDR_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   localparam logic [1:0] REG_START_BYTE   = 2'd0;
   localparam logic [1:0] REG_FIRST_TYPE   = 2'd1;
   localparam logic [1:0] REG_SECOND_TYPE  = 2'd2;
   localparam logic [1:0] REG_LENGTH_LIMIT = 2'd3;

   localparam logic [7:0] RESET_START_BYTE   = 8'd170;
   localparam logic [7:0] RESET_FIRST_TYPE   = 8'd1;
   localparam logic [7:0] RESET_SECOND_TYPE  = 8'd2;
   localparam logic [7:0] RESET_LENGTH_LIMIT = 8'd64;

   // Verdict codes carried on the status field
   localparam logic [1:0] STATUS_INCOMPLETE = 2'd0;
   localparam logic [1:0] STATUS_GOOD       = 2'd1;
   localparam logic [1:0] STATUS_BAD        = 2'd2;

   typedef enum logic [2:0] {
      ST_HUNT     = 3'd0,
      ST_TYPE     = 3'd1,
      ST_LENGTH   = 3'd2,
      ST_PAYLOAD  = 3'd3,
      ST_CHECKSUM = 3'd4
   } stage_type;

   typedef struct packed {
      logic [7:0] start_byte_value;
      logic [7:0] first_type_code;
      logic [7:0] second_type_code;
      logic [7:0] length_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0] status;
      logic       payload_valid;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [7:0] packet_type;
      logic [7:0] packet_length;
      logic [7:0] packet_checksum;
   } result_type;

endpackage

FILE: hw/rtl/lppd_csr.sv
// ----------------------------------------------------------------------------
// Deframer register block
// APB-style register file holding the start byte, type codes and limit.
// ----------------------------------------------------------------------------
module lppd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lppd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lppd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lppd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready,
   output lppd_pkg::cfg_type                   cfg
);
   import lppd_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;
   logic [7:0] rd_byte;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];

   // Keep the low byte of a write
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_START_BYTE:   cfg_in.start_byte_value = pwdata[7:0];
            REG_FIRST_TYPE:   cfg_in.first_type_code  = pwdata[7:0];
            REG_SECOND_TYPE:  cfg_in.second_type_code = pwdata[7:0];
            REG_LENGTH_LIMIT: cfg_in.length_limit     = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_byte_value <= RESET_START_BYTE;
         cfg_ff.first_type_code  <= RESET_FIRST_TYPE;
         cfg_ff.second_type_code <= RESET_SECOND_TYPE;
         cfg_ff.length_limit     <= RESET_LENGTH_LIMIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_START_BYTE:   rd_byte = cfg_ff.start_byte_value;
         REG_FIRST_TYPE:   rd_byte = cfg_ff.first_type_code;
         REG_SECOND_TYPE:  rd_byte = cfg_ff.second_type_code;
         REG_LENGTH_LIMIT: rd_byte = cfg_ff.length_limit;
         default:          rd_byte = '0;
      endcase
   end

   assign prdata = {{(CSR_DATA_WIDTH-8){1'b0}}, rd_byte};
   assign cfg    = cfg_ff;

endmodule

FILE: hw/rtl/lppd_parser.sv
// ----------------------------------------------------------------------------
// Deframer parser
// Frame state machine; forms one result per accepted byte.
// ----------------------------------------------------------------------------
module lppd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           rx_byte,
   input  lppd_pkg::cfg_type    cfg,
   output lppd_pkg::result_type result
);
   import lppd_pkg::*;

   stage_type  stage_ff;
   stage_type  stage_in;
   logic [7:0] count_ff;
   logic [7:0] count_in;
   logic [7:0] type_ff;
   logic [7:0] type_in;
   logic [7:0] length_ff;
   logic [7:0] length_in;
   logic [8:0] count_next;
   logic       last_payload;
   logic       type_ok;
   logic       len_ok;

   assign count_next   = {1'b0, count_ff} + 9'd1;
   assign last_payload = count_next >= {1'b0, length_ff};
   assign type_ok      = (type_ff == cfg.first_type_code) ||
                         (type_ff == cfg.second_type_code);
   assign len_ok       = (length_ff != 8'd0) && (length_ff <= cfg.length_limit);

   // Next stage
   always_comb begin
      stage_in = stage_ff;
      unique case (stage_ff)
         ST_HUNT:     if (rx_byte == cfg.start_byte_value) stage_in = ST_TYPE;
         ST_TYPE:     stage_in = ST_LENGTH;
         ST_LENGTH:   stage_in = ST_PAYLOAD;
         ST_PAYLOAD:  if (last_payload) stage_in = ST_CHECKSUM;
         ST_CHECKSUM: stage_in = ST_HUNT;
         default:     stage_in = ST_HUNT;
      endcase
   end

   // Held header fields and payload counter
   always_comb begin
      count_in  = count_ff;
      type_in   = type_ff;
      length_in = length_ff;
      unique case (stage_ff)
         ST_HUNT:     count_in  = count_ff;
         ST_TYPE:     type_in   = rx_byte;
         ST_LENGTH:   length_in = rx_byte;
         ST_PAYLOAD:  count_in  = count_next[7:0];
         ST_CHECKSUM: count_in  = '0;
         default:     count_in  = '0;
      endcase
   end

   // Result for the byte now presented
   always_comb begin
      result = '0;
      unique case (stage_ff)
         ST_PAYLOAD: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
         end
         ST_CHECKSUM: begin
            result.status          = (type_ok && len_ok) ? STATUS_GOOD : STATUS_BAD;
            result.packet_type     = type_ff;
            result.packet_length   = length_ff;
            result.packet_checksum = rx_byte;
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff  <= ST_HUNT;
         count_ff  <= '0;
         type_ff   <= '0;
         length_ff <= '0;
      end else if (accept) begin
         stage_ff  <= stage_in;
         count_ff  <= count_in;
         type_ff   <= type_in;
         length_ff <= length_in;
      end
   end

   a_verdict_rearms: assert property (@(posedge clock) disable iff (reset)
      accept && stage_ff == ST_CHECKSUM |=> stage_ff == ST_HUNT && count_ff == 8'd0)
      else $error("parser did not return to hunting after checksum");

   a_payload_counts: assert property (@(posedge clock) disable iff (reset)
      accept && stage_ff == ST_PAYLOAD |=> count_ff == $past(count_ff) + 8'd1)
      else $error("payload counter did not advance");

   a_hunt_count_clear: assert property (@(posedge clock) disable iff (reset)
      stage_ff == ST_HUNT || stage_ff == ST_TYPE || stage_ff == ST_LENGTH
      |-> count_ff == 8'd0)
      else $error("payload counter not clear outside a payload");

endmodule

FILE: hw/rtl/lppd_out_reg.sv
// ----------------------------------------------------------------------------
// Deframer result register
// Holds one result until taken; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module lppd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  lppd_pkg::result_type in_result,
   output logic                 out_valid,
   input  logic                 out_ready,
   output lppd_pkg::result_type out_result
);
   import lppd_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> out_valid)
      else $error("accepted transaction did not reach the result register");

endmodule

FILE: hw/rtl/length_prefixed_packet_deframer.sv
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Hunts for a start byte and splits type, length, payload and checksum.
// ----------------------------------------------------------------------------
// One received byte enters per req transaction and exactly one rsp transaction
// comes out for it in the cycle after it is taken, in order. The block takes
// a byte in any cycle that req_ready is high; the single result register sets
// it, high whenever the register is empty or its result is being taken in the
// same cycle, so with rsp_ready held high the block sustains one byte per
// clock. Each byte is decoded against the frame state: while hunting, bytes
// other than the start byte give an empty result; then come a type byte, a
// length byte, the payload bytes (each passed out with payload_valid and its
// index, a zero length still consuming one byte) and a checksum byte that
// brings the verdict with the held type, length and the unverified checksum.
// The verdict is good only for a type matching either configured code and a
// length from 1 to the configured length limit. Write registers only while no
// transaction is in flight.
// ----------------------------------------------------------------------------
module length_prefixed_packet_deframer (
   input  logic                                clock,
   input  logic                                reset,
   // Received bytes
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_rx_byte,
   // Results
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic                                rsp_payload_valid,
   output logic [7:0]                          rsp_payload_byte,
   output logic [7:0]                          rsp_payload_index,
   output logic [7:0]                          rsp_packet_type,
   output logic [7:0]                          rsp_packet_length,
   output logic [7:0]                          rsp_packet_checksum,
   // Register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [lppd_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [lppd_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [lppd_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                pready
);
   import lppd_pkg::*;

   cfg_type    cfg;
   result_type parse_result;
   result_type rsp_result;
   logic       req_accept;

   // A transaction advances the frame state only when it is taken
   assign req_accept = req_valid && req_ready;

   lppd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Decode the incoming byte against the frame state
   lppd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .rx_byte (req_rx_byte),
      .cfg     (cfg),
      .result  (parse_result)
   );

   // Hold the result until the consumer takes it
   lppd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_result  (parse_result),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   assign rsp_status          = rsp_result.status;
   assign rsp_payload_valid   = rsp_result.payload_valid;
   assign rsp_payload_byte    = rsp_result.payload_byte;
   assign rsp_payload_index   = rsp_result.payload_index;
   assign rsp_packet_type     = rsp_result.packet_type;
   assign rsp_packet_length   = rsp_result.packet_length;
   assign rsp_packet_checksum = rsp_result.packet_checksum;

endmodule
